// File: hdl/frp_pkg.sv
package frp_pkg;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_N     = 8'h6E;

    typedef enum logic [2:0] {
        KIND_HCHAR = 3'd0,
        KIND_HEND  = 3'd1,
        KIND_BASE  = 3'd2,
        KIND_REND  = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_value;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_t;

endpackage

// File: hdl/frp_in_if.sv
interface frp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_input;

    modport source (output valid, output text_byte, output end_of_input, input ready);
    modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

// File: hdl/frp_out_if.sv
interface frp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_value;
    logic       last;

    modport source (output valid, output kind, output char_value, output last, input ready);
    modport sink   (input valid, input kind, input char_value, input last, output ready);
endinterface

// File: hdl/fasta_record_parser.sv
// channel | role   | payload                           | accepted when
// text    | sink   | text_byte[8], end_of_input[1]     | valid && ready
// token   | source | kind[3], char_value[8], last[1]   | valid && ready
//
// One text item per cycle is accepted while ready; parse mode updates in the accept cycle.
// Results enter a four-entry queue and leave one per cycle while token.ready is high;
// the first shows in the cycle after accept. End of input in a header yields two results.
// text.ready is high while the queue has room for two results; token stalls back up there.
// rst_n clears the mode to seeking and empties the queue asynchronously.
module fasta_record_parser (
    input  logic       clk,
    input  logic       rst_n,
    frp_in_if.sink     text,
    frp_out_if.source  token
);
    import frp_pkg::*;

    logic       accept;
    logic       room;
    logic [1:0] push_cnt;
    step_t      step;
    result_t    head;

    assign text.ready = room;
    assign accept     = text.valid && room;
    assign push_cnt   = accept ? step.count : 2'd0;

    frp_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .text_byte    (text.text_byte),
        .end_of_input (text.end_of_input),
        .step         (step)
    );

    frp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .r0        (step.r0),
        .r1        (step.r1),
        .room      (room),
        .out_valid (token.valid),
        .out_ready (token.ready),
        .head      (head)
    );

    assign token.kind       = head.kind;
    assign token.char_value = head.char_value;
    assign token.last       = head.last;

endmodule

// File: hdl/frp_step.sv
module frp_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     text_byte,
    input  logic           end_of_input,
    output frp_pkg::step_t step
);
    import frp_pkg::*;

    typedef enum logic [4:0] {
        MODE_SEEK   = 5'b00001,
        MODE_LEAD   = 5'b00010,
        MODE_HEADER = 5'b00100,
        MODE_SEQ    = 5'b01000,
        MODE_HALT   = 5'b10000
    } mode_t;

    mode_t      mode_reg;
    mode_t      mode_next;
    logic       is_ws;
    logic [7:0] lower;
    logic       is_base;

    assign is_ws = (text_byte == CH_SPACE) || (text_byte >= 8'h09 && text_byte <= 8'h0D);
    assign lower = (text_byte >= 8'h41 && text_byte <= 8'h5A) ? text_byte + 8'd32 : text_byte;
    assign is_base = (lower == CH_A) || (lower == CH_C) || (lower == CH_G) ||
                     (lower == CH_T) || (lower == CH_U) || (lower == CH_N);

    always_comb
    begin
        mode_next           = mode_reg;
        step.count          = 2'd0;
        step.r0.kind        = KIND_HCHAR;
        step.r0.char_value  = 8'd0;
        step.r0.last        = 1'b1;
        step.r1.kind        = KIND_REND;
        step.r1.char_value  = 8'd0;
        step.r1.last        = 1'b1;
        if (end_of_input)
        begin
            unique case (mode_reg)
                MODE_SEEK, MODE_LEAD:
                begin
                    mode_next = MODE_SEEK;
                end
                MODE_HEADER:
                begin
                    step.count   = 2'd2;
                    step.r0.kind = KIND_HEND;
                    step.r0.last = 1'b0;
                    mode_next    = MODE_SEEK;
                end
                MODE_SEQ:
                begin
                    step.count   = 2'd1;
                    step.r0.kind = KIND_REND;
                    mode_next    = MODE_SEEK;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_SEEK:
                begin
                    if (text_byte == CH_GT)
                        mode_next = MODE_LEAD;
                end
                MODE_LEAD:
                begin
                    if (text_byte == CH_NL)
                        mode_next = MODE_HEADER;
                    else if (!is_ws)
                    begin
                        step.count         = 2'd1;
                        step.r0.char_value = text_byte;
                        mode_next          = MODE_HEADER;
                    end
                end
                MODE_HEADER:
                begin
                    step.count = 2'd1;
                    if (text_byte == CH_NL)
                    begin
                        step.r0.kind = KIND_HEND;
                        mode_next    = MODE_SEQ;
                    end
                    else
                        step.r0.char_value = is_ws ? CH_SPACE : text_byte;
                end
                MODE_SEQ:
                begin
                    if (text_byte == CH_GT)
                    begin
                        step.count   = 2'd1;
                        step.r0.kind = KIND_REND;
                        mode_next    = MODE_LEAD;
                    end
                    else if (!is_ws)
                    begin
                        step.count = 2'd1;
                        if (is_base)
                        begin
                            step.r0.kind       = KIND_BASE;
                            step.r0.char_value = lower;
                        end
                        else
                        begin
                            step.r0.kind = KIND_ERROR;
                            mode_next    = MODE_HALT;
                        end
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_SEEK;
        else if (accept)
            mode_reg <= mode_next;
    end

`ifndef SYNTH
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HALT |=> mode_reg == MODE_HALT)
        else $error("halted mode left without reset");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step.count != 2'd0 && step.r0.kind == KIND_ERROR |=> mode_reg == MODE_HALT)
        else $error("invalid base did not halt parser");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HALT |-> step.count == 2'd0)
        else $error("halted parser produced a result");
`endif

endmodule

// File: hdl/frp_queue.sv
module frp_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    push_cnt,
    input  frp_pkg::result_t              r0,
    input  frp_pkg::result_t              r1,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output frp_pkg::result_t              head
);
    import frp_pkg::*;

    result_t            q_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_inc;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign pop         = out_valid && out_ready;
    assign out_valid   = count_reg != '0;
    assign head        = q_reg[rd_ptr_reg];
    assign room        = count_reg <= CNT_W'(QDEPTH - 2);
    assign wr_inc      = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            q_reg[wr_ptr_reg] <= r0;
        if (push_cnt == 2'd2)
            q_reg[wr_inc] <= r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> CNT_W'(push_cnt) + count_reg <= CNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |=> out_valid)
        else $error("pushed result not visible");
`endif

endmodule

// File: verif/tb_fasta_record_parser.sv
`timescale 1ns / 100ps

module tb_fasta_record_parser;

    import frp_pkg::*;

    localparam int          ITEMS       = 1650;
    localparam int          HOLD_AT     = 500;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_EVERY = 400;
    localparam int          TAIL_CYCLES = 20;
    localparam int unsigned LIMIT       = 1000000;

    typedef enum logic [2:0] {
        SEEKING,
        LEADING,
        IN_HEADER,
        IN_SEQUENCE,
        HALTED
    } mode_t;

    typedef struct {
        logic [7:0] text_byte;
        logic       end_of_input;
        bit         drain;
    } text_item_t;

    logic clk = 1'b0;
    logic rst_n;

    frp_in_if  text_bus ();
    frp_out_if token_bus ();

    fasta_record_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_bus),
        .token (token_bus)
    );

    text_item_t  text_items [$];
    result_t     tokens_due [$];

    mode_t       gen_mode   = SEEKING;
    mode_t       model_mode = SEEKING;
    bit          halt_ok    = 1'b0;
    bit          drain_next = 1'b0;

    bit          text_taken = 1'b0;
    int unsigned send_gap   = 0;
    int unsigned take_gap   = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    int unsigned cycles      = 0;
    int unsigned text_count  = 0;
    int unsigned token_count = 0;
    int unsigned text_stalls = 0;
    int unsigned n_hchar     = 0;
    int unsigned n_base      = 0;
    int unsigned n_record    = 0;
    int unsigned mismatches  = 0;
    logic        calm;

    assign calm = (cycles % 1200) < 200;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void parse_byte(input mode_t mode, input logic [7:0] c,
                                       input logic eoi, output mode_t nxt,
                                       output result_t r0, output result_t r1,
                                       output int n);
        logic [7:0] b;
        n   = 0;
        nxt = mode;
        r0  = '0;
        r1  = '0;
        b   = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (eoi)
        begin
            case (mode)
                SEEKING, LEADING: nxt = SEEKING;
                IN_HEADER:
                begin
                    r0.kind = KIND_HEND;
                    r1.kind = KIND_REND;
                    n       = 2;
                    nxt     = SEEKING;
                end
                IN_SEQUENCE:
                begin
                    r0.kind = KIND_REND;
                    n       = 1;
                    nxt     = SEEKING;
                end
                default: ;
            endcase
        end
        else
        begin
            case (mode)
                SEEKING:
                    if (c == CH_GT)
                        nxt = LEADING;
                LEADING:
                    if (c == CH_NL)
                        nxt = IN_HEADER;
                    else if (!is_space(c))
                    begin
                        r0.kind       = KIND_HCHAR;
                        r0.char_value = c;
                        n             = 1;
                        nxt           = IN_HEADER;
                    end
                IN_HEADER:
                    if (c == CH_NL)
                    begin
                        r0.kind = KIND_HEND;
                        n       = 1;
                        nxt     = IN_SEQUENCE;
                    end
                    else
                    begin
                        r0.kind       = KIND_HCHAR;
                        r0.char_value = is_space(c) ? CH_SPACE : c;
                        n             = 1;
                    end
                IN_SEQUENCE:
                    if (c == CH_GT)
                    begin
                        r0.kind = KIND_REND;
                        n       = 1;
                        nxt     = LEADING;
                    end
                    else if (!is_space(c))
                    begin
                        n = 1;
                        if (b == CH_A || b == CH_C || b == CH_G || b == CH_T ||
                            b == CH_U || b == CH_N)
                        begin
                            r0.kind       = KIND_BASE;
                            r0.char_value = b;
                        end
                        else
                        begin
                            r0.kind = KIND_ERROR;
                            nxt     = HALTED;
                        end
                    end
                default: ;
            endcase
        end
        if (n == 1)
            r0.last = 1'b1;
        else if (n == 2)
            r1.last = 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] random_base();
        logic [7:0] b;
        case ($urandom_range(5))
            0:       b = CH_A;
            1:       b = CH_C;
            2:       b = CH_G;
            3:       b = CH_T;
            4:       b = CH_U;
            default: b = CH_N;
        endcase
        if ($urandom_range(1) == 1)
            b = b - 8'd32;
        return b;
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(4))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0B;
            3:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    task automatic push_text(input logic [7:0] c, input logic eoi);
        mode_t   nxt;
        result_t r0;
        result_t r1;
        int      n;
        parse_byte(gen_mode, c, eoi, nxt, r0, r1, n);
        if (!halt_ok && n > 0 && r0.kind == KIND_ERROR)
        begin
            c = random_base();
            parse_byte(gen_mode, c, eoi, nxt, r0, r1, n);
        end
        gen_mode = nxt;
        text_items.push_back('{c, eoi, drain_next});
        drain_next = 1'b0;
    endtask

    task automatic add_byte(input logic [7:0] c);
        push_text(c, 1'b0);
    endtask

    task automatic add_end();
        push_text(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic gen_record();
        logic [7:0] c;
        int         len;
        int         r;
        if (gen_mode != LEADING)
            add_byte(CH_GT);
        repeat ($urandom_range(0, 2))
            add_byte(random_blank());
        if ($urandom_range(9) < 3)
            add_byte(CH_NL);
        len = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
        begin
            do
                c = 8'($urandom_range(255));
            while (c == CH_NL);
            add_byte(c);
        end
        if ($urandom_range(9) == 0)
        begin
            add_end();
            return;
        end
        add_byte(CH_NL);
        len = $urandom_range(0, 40);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(99);
            if (r < 70)
                add_byte(random_base());
            else if (r < 82)
                add_byte(random_blank());
            else if (r < 90)
                add_byte(CH_NL);
            else
                add_byte(8'($urandom_range(255)));
        end
        r = $urandom_range(99);
        if (r < 55)
            add_byte(CH_GT);
        else if (r < 85)
            add_end();
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < 50)
            $display("token %0d: %s is %0h, expected %0h", token_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        result_t    want;
        mode_t      nxt;
        result_t    r0;
        result_t    r1;
        int         n;
        cycles++;
        if (rst_n)
        begin
            if (token_bus.valid && token_bus.ready)
            begin
                token_count++;
                if (tokens_due.size() == 0)
                    report_mismatch("token with none due, kind", token_bus.kind, 0);
                else
                begin
                    want = tokens_due.pop_front();
                    if (token_bus.kind !== want.kind)
                        report_mismatch("kind", token_bus.kind, want.kind);
                    if (token_bus.char_value !== want.char_value)
                        report_mismatch("char_value", token_bus.char_value, want.char_value);
                    if (token_bus.last !== want.last)
                        report_mismatch("last", token_bus.last, want.last);
                    case (want.kind)
                        KIND_HCHAR: n_hchar++;
                        KIND_BASE:  n_base++;
                        KIND_REND:  n_record++;
                        default: ;
                    endcase
                end
            end
            if (text_bus.valid && !text_bus.ready)
                text_stalls++;
            if (text_bus.valid && text_bus.ready)
            begin
                parse_byte(model_mode, text_bus.text_byte, text_bus.end_of_input,
                           nxt, r0, r1, n);
                model_mode = nxt;
                if (n > 0)
                    tokens_due.push_back(r0);
                if (n > 1)
                    tokens_due.push_back(r1);
                void'(text_items.pop_front());
                text_taken = 1'b1;
                text_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left--;
        else if (!hold_done && text_count >= HOLD_AT)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
    end

    always @(negedge clk)
    begin : send
        logic nv;
        nv         = text_bus.valid && !text_taken;
        text_taken = 1'b0;
        if (!rst_n || text_items.size() == 0)
            nv = 1'b0;
        else if (!nv)
        begin
            if (hold_left != 0)
                send_gap = 0;
            if (text_items[0].drain && tokens_due.size() != 0)
                nv = 1'b0;
            else if (send_gap != 0)
                send_gap--;
            else
            begin
                nv       = 1'b1;
                send_gap = pick_gap();
            end
        end
        text_bus.valid <= nv;
        if (nv)
        begin
            text_bus.text_byte    <= text_items[0].text_byte;
            text_bus.end_of_input <= text_items[0].end_of_input;
        end
        else
        begin
            text_bus.text_byte    <= 8'($urandom_range(255));
            text_bus.end_of_input <= 1'($urandom_range(1));
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_left != 0)
            token_bus.ready <= 1'b0;
        else if (take_gap != 0)
        begin
            take_gap--;
            token_bus.ready <= 1'b0;
        end
        else
        begin
            token_bus.ready <= 1'b1;
            take_gap = pick_gap();
        end
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int next_drain;
        rst_n                 = 1'b0;
        text_bus.valid        = 1'b0;
        text_bus.text_byte    = 8'h00;
        text_bus.end_of_input = 1'b0;
        token_bus.ready       = 1'b0;

        add_byte(8'h00);
        add_byte(8'hFF);
        add_end();
        add_byte(CH_GT);
        add_byte(8'h09);
        add_byte(CH_NL);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'h0D);
        add_byte("Z");
        add_byte(CH_NL);
        add_byte("A");
        add_byte("c");
        add_byte("G");
        add_byte("t");
        add_byte("U");
        add_byte("N");
        add_byte(8'h0C);
        add_byte(CH_NL);
        add_byte(CH_GT);
        add_byte("x");
        add_end();
        add_byte(CH_GT);
        add_end();
        add_byte(CH_GT);
        add_byte(CH_NL);
        add_byte(CH_NL);
        add_byte("g");
        add_end();

        drain_next = 1'b1;
        next_drain = text_items.size() + DRAIN_EVERY;
        while (text_items.size() < ITEMS)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_end();
                repeat ($urandom_range(1, 6))
                begin
                    logic [7:0] c;
                    do
                        c = 8'($urandom_range(255));
                    while (c == CH_GT);
                    add_byte(c);
                end
            end
            gen_record();
            if (text_items.size() >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain += DRAIN_EVERY;
            end
        end

        add_end();
        halt_ok = 1'b1;
        add_byte(CH_GT);
        add_byte(CH_NL);
        add_byte("h");
        add_byte(CH_NL);
        add_byte("a");
        add_byte("x");
        add_byte("A");
        add_end();
        add_byte(CH_GT);
        add_byte("q");

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (text_items.size() != 0 || tokens_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d text items, %0d tokens in %0d cycles: %0d header chars, %0d bases, %0d records",
                 text_count, token_count, cycles, n_hchar, n_base, n_record);
        $display("input stalled %0d cycles; output hold-off, drain pauses and error halt done",
                 text_stalls);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
